// ===== design/khss_pkg.sv =====
// ----------------------------------------------------------------------------
// khss_pkg
// Shared types and constants for the key hash shard selector.
// ----------------------------------------------------------------------------
`default_nettype none

package khss_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned HASH_W  = 32;
  localparam int unsigned SHARD_W = 16;
  localparam int unsigned CNT_W   = $clog2(HASH_W);

  localparam logic [HASH_W-1:0] HASH_MULT = HASH_W'(31);

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [HASH_W-1:0]  hash_t;
  typedef logic [SHARD_W-1:0] shard_t;

  // status of the remainder unit as seen by the top level
  typedef struct packed {
    logic busy;       // holding or working on a key, no new bytes
    logic res_valid;  // remainder ready to move to the output register
  } khss_mod_stat_t;

endpackage

`default_nettype wire

// ===== design/key_hash_shard_select.sv =====
// ----------------------------------------------------------------------------
// key_hash_shard_select
// Hashes key bytes (hash * 31 + byte) and gives hash mod the shard count as
// the shard index on the last byte of each key.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+---------------------------
//   in_     | in  | in_valid/in_stall   | in_data_byte, in_last_byte
//   out_    | out | out_valid/out_stall | out_shard_sel
//   cfg_    | in  | cfg_valid/cfg_ready | cfg_num_shards
//
// A byte not marked last is absorbed without a stall while the remainder
// unit is idle, so bytes stream back to back. A last byte starts the
// remainder unit: 32 one-bit restoring steps, then a load of the output
// register, which raises out_valid. in_stall is high while the unit works,
// and longer while a waiting result keeps the output register full.
// Synchronous active-low reset; shard count resets to 1, hash to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module key_hash_shard_select (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire khss_pkg::byte_t   in_data_byte,
  input  wire                    in_last_byte,
  output logic                   out_valid,
  input  wire                    out_stall,
  output khss_pkg::shard_t       out_shard_sel,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire khss_pkg::shard_t  cfg_num_shards
);
  import khss_pkg::*;

  khss_mod_stat_t mod_stat;
  hash_t          hash_upd;
  shard_t         remainder;
  shard_t         num_shards_r;
  shard_t         out_idx_r;
  logic           out_valid_r, out_valid_nxt;
  logic           in_xfer;
  logic           out_load;

  assign in_stall  = mod_stat.busy;
  assign in_xfer   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // result moves to the output register once that register is free
  assign out_load = mod_stat.res_valid & (~out_valid_r | ~out_stall);

  khss_hash u_hash (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (in_xfer),
    .byte_last (in_last_byte),
    .data_byte (in_data_byte),
    .hash_upd  (hash_upd)
  );

  khss_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_xfer & in_last_byte),
    .dividend  (hash_upd),
    .divisor   (num_shards_r),
    .take      (out_load),
    .stat      (mod_stat),
    .remainder (remainder)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_shards_r <= SHARD_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      // zero would mean no shards; hold the least legal count instead
      num_shards_r <= (cfg_num_shards == '0) ? SHARD_W'(1) : cfg_num_shards;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_idx_r <= remainder;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_shard_sel = out_idx_r;

endmodule

`default_nettype wire

// ===== design/khss_hash.sv =====
// ----------------------------------------------------------------------------
// khss_hash
// Running polynomial hash: hash * 31 + byte, wrapping at 32 bits,
// cleared after the last byte of a key.
// ----------------------------------------------------------------------------
`default_nettype none

module khss_hash (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   byte_en,
  input  wire                   byte_last,
  input  wire khss_pkg::byte_t  data_byte,
  output khss_pkg::hash_t       hash_upd
);
  import khss_pkg::*;

  hash_t hash_r;
  hash_t hash_nxt;

  // hash_upd includes the byte being transferred this cycle
  assign hash_upd = HASH_W'(hash_r * HASH_MULT) + HASH_W'(data_byte);

  always_comb begin
    hash_nxt = hash_r;
    if (byte_en) begin
      hash_nxt = byte_last ? '0 : hash_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= '0;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/khss_mod.sv =====
// ----------------------------------------------------------------------------
// khss_mod
// Iterative restoring remainder: one dividend bit per cycle through a
// shared 17-bit compare/subtract, 32 steps per key.
// ----------------------------------------------------------------------------
`default_nettype none

module khss_mod (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  input  wire khss_pkg::hash_t    dividend,
  input  wire khss_pkg::shard_t   divisor,
  input  wire                     take,
  output khss_pkg::khss_mod_stat_t stat,
  output khss_pkg::shard_t        remainder
);
  import khss_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  hash_t            quo_r, quo_nxt;
  shard_t           rem_r, rem_nxt;
  shard_t           div_r, div_nxt;

  logic [SHARD_W:0] trial;
  logic [SHARD_W:0] diff;

  assign trial = {rem_r, quo_r[HASH_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
          cnt_nxt   = '0;
          quo_nxt   = dividend;
          rem_nxt   = '0;
          div_nxt   = divisor;
        end
      end
      ST_RUN: begin
        quo_nxt = {quo_r[HASH_W-2:0], 1'b0};
        // remainder stays below the divisor, so trial < 2 * divisor
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = diff[SHARD_W-1:0];
        end else begin
          rem_nxt = trial[SHARD_W-1:0];
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(HASH_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign stat.busy      = (state_r != ST_IDLE);
  assign stat.res_valid = (state_r == ST_DONE);
  assign remainder      = rem_r;

endmodule

`default_nettype wire
